// ----- hw/rtl/fpp_pkg.sv -----
// Shared types, constants and codes of the framed packet parser.
`default_nettype none

package fpp_pkg;

  // Frame format
  localparam logic [7:0]  SYNC_FIRST  = 8'hA5;
  localparam logic [7:0]  SYNC_SECOND = 8'h5A;
  localparam logic [3:0]  HDR_LEN     = 4'd8;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h1021;
  localparam logic [15:0] CRC_TOP     = 16'h8000;

  // Default largest accepted payload length
  localparam int MAX_PAYLOAD_DEF = 128;

  // Event codes
  localparam logic [2:0] EV_PAYLOAD = 3'd0;
  localparam logic [2:0] EV_ACCEPT  = 3'd1;
  localparam logic [2:0] EV_BADLEN  = 3'd2;
  localparam logic [2:0] EV_CRC     = 3'd3;
  localparam logic [2:0] EV_VERSION = 3'd4;
  localparam logic [2:0] EV_TYPE    = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] REG_VERSION = 3'd0;
  localparam logic [2:0] REG_CMD_A   = 3'd1;
  localparam logic [2:0] REG_CMD_B   = 3'd2;
  localparam logic [2:0] REG_CMD_C   = 3'd3;
  localparam logic [2:0] REG_CMD_D   = 3'd4;

  // One result transaction
  typedef struct packed {
    logic [2:0]  event_kind;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] scan_number;
    logic [15:0] sequence_number;
    logic [7:0]  payload_length;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_offset;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fpp_crc16_step.sv -----
// Byte-wide CRC-16/CCITT-FALSE update.
`default_nettype none

module fpp_crc16_step
  import fpp_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data_in,
  output logic      [15:0] crc_out
);

  // Shift the byte through the polynomial, MSB first
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {data_in, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

// ----- hw/rtl/fpp_out_skid.sv -----
// Output register with skid stage for the result channel.
`default_nettype none

module fpp_out_skid
  import fpp_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res_data,
  output logic         room,
  output logic         out_valid,
  input  wire logic    out_ready,
  output result_t      out_data
);

  logic    out_valid_r;
  logic    skid_valid_r;
  result_t out_data_r;
  result_t skid_data_r;

  // Take a new result only while the skid stage is empty
  assign room      = !skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (!out_valid_r || out_ready) begin
      out_data_r <= skid_valid_r ? skid_data_r : res_data;
    end else if (res_valid && !skid_valid_r) begin
      skid_data_r <= res_data;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/framed_packet_parser_crc16.sv -----
// Framed packet parser: sync hunt, header, payload pass-through, CRC-16 verdict.
// A result is registered into the output register, or into the skid stage while the output is stalled.
// Throughput: one byte per cycle while in_ready is high; the byte-wide CRC update and phase logic are combinational.
// A result stalled at the output parks in a skid stage; input stalls only when both are full.
// Reset (rst_n low, synchronous): parser back to sync hunt, CRC 0xFFFF, counts zero,
// configuration registers to defaults, result buffers empty.
`default_nettype none

module framed_packet_parser_crc16
  import fpp_pkg::*;
#(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  // Result channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_event_kind,
  output logic [7:0]       out_frame_type,
  output logic [7:0]       out_frame_flags,
  output logic [15:0]      out_scan_number,
  output logic [15:0]      out_sequence_number,
  output logic [7:0]       out_payload_length,
  output logic [7:0]       out_payload_byte,
  output logic [7:0]       out_payload_offset,
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  // Parse phases
  localparam logic [2:0] PH_SYNC0   = 3'd0;
  localparam logic [2:0] PH_SYNC1   = 3'd1;
  localparam logic [2:0] PH_HEADER  = 3'd2;
  localparam logic [2:0] PH_PAYLOAD = 3'd3;
  localparam logic [2:0] PH_CRCLO   = 3'd4;
  localparam logic [2:0] PH_CRCHI   = 3'd5;

  // Configuration registers
  logic [7:0] version_r;
  logic [7:0] cmd_a_r;
  logic [7:0] cmd_b_r;
  logic [7:0] cmd_c_r;
  logic [7:0] cmd_d_r;

  // Parser state
  logic [2:0]  phase_r,    phase_nxt;
  logic [3:0]  hdr_cnt_r,  hdr_cnt_nxt;
  logic [7:0]  pay_cnt_r,  pay_cnt_nxt;
  logic [15:0] crc_r,      crc_nxt;
  logic [7:0]  crc_lo_r,   crc_lo_nxt;
  logic [7:0]  hdr_r [8];
  logic [7:0]  hdr_nxt [8];

  logic        in_fire;
  logic        room;
  logic [15:0] crc_fed;
  logic        res_valid;
  result_t     res;
  result_t     out_data;
  logic [2:0]  cfg_idx;
  logic        cfg_wr;

  // APB write and read
  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[4:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      version_r <= 8'd1;
      cmd_a_r   <= 8'd1;
      cmd_b_r   <= 8'd2;
      cmd_c_r   <= 8'd3;
      cmd_d_r   <= 8'd4;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VERSION: version_r <= cfg_pwdata[7:0];
        REG_CMD_A:   cmd_a_r   <= cfg_pwdata[7:0];
        REG_CMD_B:   cmd_b_r   <= cfg_pwdata[7:0];
        REG_CMD_C:   cmd_c_r   <= cfg_pwdata[7:0];
        REG_CMD_D:   cmd_d_r   <= cfg_pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VERSION: cfg_prdata = {24'h0, version_r};
      REG_CMD_A:   cfg_prdata = {24'h0, cmd_a_r};
      REG_CMD_B:   cfg_prdata = {24'h0, cmd_b_r};
      REG_CMD_C:   cfg_prdata = {24'h0, cmd_c_r};
      REG_CMD_D:   cfg_prdata = {24'h0, cmd_d_r};
      default:     cfg_prdata = 32'h0;
    endcase
  end

  // CRC update of the incoming byte
  fpp_crc16_step u_crc (
    .crc_in  (crc_r),
    .data_in (in_rx_byte),
    .crc_out (crc_fed)
  );

  assign in_ready = room;
  assign in_fire  = in_valid && room;

  // Parse one byte
  always_comb begin
    logic [3:0]  hc_inc;
    logic [7:0]  pc_inc;
    logic [15:0] got;
    logic        type_hit;
    logic        restart;
    logic [2:0]  kind;
    logic [7:0]  pbyte;
    logic [7:0]  poff;

    phase_nxt   = phase_r;
    hdr_cnt_nxt = hdr_cnt_r;
    pay_cnt_nxt = pay_cnt_r;
    crc_nxt     = crc_r;
    crc_lo_nxt  = crc_lo_r;
    for (int i = 0; i < 8; i++) begin
      hdr_nxt[i] = hdr_r[i];
    end
    res_valid = 1'b0;
    restart   = 1'b0;
    kind      = EV_PAYLOAD;
    pbyte     = 8'h00;
    poff      = 8'h00;
    hc_inc    = hdr_cnt_r + 4'd1;
    pc_inc    = pay_cnt_r + 8'd1;
    got       = {in_rx_byte, crc_lo_r};
    type_hit  = (hdr_r[1] == cmd_a_r) || (hdr_r[1] == cmd_b_r) ||
                (hdr_r[1] == cmd_c_r) || (hdr_r[1] == cmd_d_r);

    case (phase_r)
      PH_SYNC0: begin
        if (in_rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_SYNC1: begin
        if (in_rx_byte == SYNC_SECOND) begin
          hdr_cnt_nxt = 4'd0;
          crc_nxt     = CRC_INIT;
          phase_nxt   = PH_HEADER;
        end else if (in_rx_byte == SYNC_FIRST) begin
          phase_nxt = PH_SYNC1;
        end else begin
          phase_nxt = PH_SYNC0;
        end
      end
      PH_HEADER: begin
        hdr_nxt[hdr_cnt_r[2:0]] = in_rx_byte;
        hdr_cnt_nxt = hc_inc;
        crc_nxt     = crc_fed;
        if (hc_inc >= HDR_LEN) begin
          pay_cnt_nxt = 8'd0;
          if (hdr_nxt[7] > MAX_LEN) begin
            res_valid = 1'b1;
            kind      = EV_BADLEN;
            restart   = 1'b1;
          end else if (hdr_nxt[7] == 8'd0) begin
            phase_nxt = PH_CRCLO;
          end else begin
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        crc_nxt     = crc_fed;
        pay_cnt_nxt = pc_inc;
        if (pc_inc >= hdr_r[7]) begin
          phase_nxt = PH_CRCLO;
        end
        res_valid = 1'b1;
        kind      = EV_PAYLOAD;
        pbyte     = in_rx_byte;
        poff      = pay_cnt_r;
      end
      PH_CRCLO: begin
        crc_lo_nxt = in_rx_byte;
        phase_nxt  = PH_CRCHI;
      end
      PH_CRCHI: begin
        res_valid = 1'b1;
        restart   = 1'b1;
        if (got != crc_r) begin
          kind = EV_CRC;
        end else if (hdr_r[0] != version_r) begin
          kind = EV_VERSION;
        end else if (type_hit) begin
          kind = EV_ACCEPT;
        end else begin
          kind = EV_TYPE;
        end
      end
      default: begin
        restart = 1'b1;
      end
    endcase

    // Drop back to the hunt
    if (restart) begin
      phase_nxt   = PH_SYNC0;
      hdr_cnt_nxt = 4'd0;
      pay_cnt_nxt = 8'd0;
      crc_nxt     = CRC_INIT;
      crc_lo_nxt  = 8'd0;
    end

    res.event_kind      = kind;
    res.frame_type      = hdr_nxt[1];
    res.frame_flags     = hdr_nxt[2];
    res.scan_number     = {hdr_nxt[4], hdr_nxt[3]};
    res.sequence_number = {hdr_nxt[6], hdr_nxt[5]};
    res.payload_length  = hdr_nxt[7];
    res.payload_byte    = pbyte;
    res.payload_offset  = poff;
  end

  // Advance parser state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_SYNC0;
      hdr_cnt_r <= 4'd0;
      pay_cnt_r <= 8'd0;
      crc_r     <= CRC_INIT;
      crc_lo_r  <= 8'd0;
    end else if (in_fire) begin
      phase_r   <= phase_nxt;
      hdr_cnt_r <= hdr_cnt_nxt;
      pay_cnt_r <= pay_cnt_nxt;
      crc_r     <= crc_nxt;
      crc_lo_r  <= crc_lo_nxt;
    end
  end

  // Header bytes need no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      for (int i = 0; i < 8; i++) begin
        hdr_r[i] <= hdr_nxt[i];
      end
    end
  end

  // Result buffering
  fpp_out_skid u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (in_fire && res_valid),
    .res_data  (res),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign out_event_kind      = out_data.event_kind;
  assign out_frame_type      = out_data.frame_type;
  assign out_frame_flags     = out_data.frame_flags;
  assign out_scan_number     = out_data.scan_number;
  assign out_sequence_number = out_data.sequence_number;
  assign out_payload_length  = out_data.payload_length;
  assign out_payload_byte    = out_data.payload_byte;
  assign out_payload_offset  = out_data.payload_offset;

endmodule

`default_nettype wire

// ----- dv/tb_framed_packet_parser_crc16.sv -----
// Testbench for the framed packet parser: directed frames, random framed traffic, self-checking.
module tb_framed_packet_parser_crc16;
  import fpp_pkg::*;

  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [7:0] LEN_LIMIT   = 8'(MAX_PAYLOAD_DEF);
  // Register slots past the end of the register list
  localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REG_SPARE_LAST  = 3'd7;

  typedef enum logic [2:0] {
    HUNT_FIRST, HUNT_SECOND, IN_HEADER, IN_PAYLOAD, CRC_LOW, CRC_HIGH
  } parse_phase_e;

  typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_RUNS} rx_mode_e;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_event_kind;
  logic [7:0]  out_frame_type;
  logic [7:0]  out_frame_flags;
  logic [15:0] out_scan_number;
  logic [15:0] out_sequence_number;
  logic [7:0]  out_payload_length;
  logic [7:0]  out_payload_byte;
  logic [7:0]  out_payload_offset;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = 5'd0;
  logic [31:0] cfg_pwdata = 32'd0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  framed_packet_parser_crc16 uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_rx_byte(in_rx_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_event_kind(out_event_kind), .out_frame_type(out_frame_type),
    .out_frame_flags(out_frame_flags), .out_scan_number(out_scan_number),
    .out_sequence_number(out_sequence_number), .out_payload_length(out_payload_length),
    .out_payload_byte(out_payload_byte), .out_payload_offset(out_payload_offset),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Parser shadow state and configuration copy
  parse_phase_e phase;
  logic [3:0]   hdr_count;
  logic [7:0]   hdr_bytes [8];
  logic [7:0]   pay_count;
  logic [15:0]  crc_acc;
  logic [7:0]   crc_low;
  logic [7:0]   cfg_version;
  logic [7:0]   cmd_codes [4];

  result_t      expected_events [$];
  logic [7:0]   tx_bytes [$];
  int           mismatches = 0;
  int           bytes_accepted = 0;
  int           frame_bytes_queued = 0;
  int           results_seen = 0;
  int           kind_seen [8];
  int           burst_left = 0;
  int           cycles = 0;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc_next(input logic [15:0] c_in, input logic [7:0] b);
    logic [15:0] c;
    int          i;
    c = c_in ^ {b, 8'h00};
    for (i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  function automatic result_t frame_result(input logic [2:0] kind, input logic [7:0] pbyte,
                                           input logic [7:0] poff);
    result_t r;
    r.event_kind      = kind;
    r.frame_type      = hdr_bytes[1];
    r.frame_flags     = hdr_bytes[2];
    r.scan_number     = {hdr_bytes[4], hdr_bytes[3]};
    r.sequence_number = {hdr_bytes[6], hdr_bytes[5]};
    r.payload_length  = hdr_bytes[7];
    r.payload_byte    = pbyte;
    r.payload_offset  = poff;
    return r;
  endfunction

  function automatic void rearm_hunt();
    phase     = HUNT_FIRST;
    hdr_count = 4'd0;
    pay_count = 8'd0;
    crc_acc   = CRC_INIT;
    crc_low   = 8'd0;
  endfunction

  function automatic bit type_known(input logic [7:0] t);
    return t == cmd_codes[0] || t == cmd_codes[1] || t == cmd_codes[2] || t == cmd_codes[3];
  endfunction

  // Advance the shadow parser by one byte; return 1 when it yields a result
  function automatic bit parse_rx_byte(input logic [7:0] b, output result_t r);
    logic [15:0] got_crc;
    logic [7:0]  off;
    bit          hit;
    hit = 1'b0;
    r   = '0;
    case (phase)
      HUNT_FIRST: begin
        if (b == SYNC_FIRST) phase = HUNT_SECOND;
      end
      HUNT_SECOND: begin
        if (b == SYNC_SECOND) begin
          hdr_count = 4'd0;
          crc_acc   = CRC_INIT;
          phase     = IN_HEADER;
        end else if (b != SYNC_FIRST) begin
          phase = HUNT_FIRST;
        end
      end
      IN_HEADER: begin
        hdr_bytes[hdr_count[2:0]] = b;
        hdr_count = hdr_count + 4'd1;
        crc_acc   = crc_next(crc_acc, b);
        if (hdr_count >= HDR_LEN) begin
          pay_count = 8'd0;
          if (hdr_bytes[7] > LEN_LIMIT) begin
            r   = frame_result(EV_BADLEN, 8'd0, 8'd0);
            hit = 1'b1;
            rearm_hunt();
          end else begin
            phase = (hdr_bytes[7] == 8'd0) ? CRC_LOW : IN_PAYLOAD;
          end
        end
      end
      IN_PAYLOAD: begin
        off       = pay_count;
        crc_acc   = crc_next(crc_acc, b);
        pay_count = pay_count + 8'd1;
        if (pay_count >= hdr_bytes[7]) phase = CRC_LOW;
        r   = frame_result(EV_PAYLOAD, b, off);
        hit = 1'b1;
      end
      CRC_LOW: begin
        crc_low = b;
        phase   = CRC_HIGH;
      end
      CRC_HIGH: begin
        got_crc = {b, crc_low};
        if (got_crc != crc_acc) r = frame_result(EV_CRC, 8'd0, 8'd0);
        else if (hdr_bytes[0] != cfg_version) r = frame_result(EV_VERSION, 8'd0, 8'd0);
        else if (type_known(hdr_bytes[1])) r = frame_result(EV_ACCEPT, 8'd0, 8'd0);
        else r = frame_result(EV_TYPE, 8'd0, 8'd0);
        hit = 1'b1;
        rearm_hunt();
      end
      default: rearm_hunt();
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] reg_value(input logic [2:0] idx);
    case (idx)
      REG_VERSION: return cfg_version;
      REG_CMD_A:   return cmd_codes[0];
      REG_CMD_B:   return cmd_codes[1];
      REG_CMD_C:   return cmd_codes[2];
      REG_CMD_D:   return cmd_codes[3];
      default:     return 8'd0;
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Track register writes, predict on input transactions, check output transactions
  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      rearm_hunt();
      hdr_bytes = '{default: 8'd0};
      cfg_version = 8'd1;
      cmd_codes   = '{8'd1, 8'd2, 8'd3, 8'd4};
      expected_events.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_VERSION: cfg_version  = cfg_pwdata[7:0];
          REG_CMD_A:   cmd_codes[0] = cfg_pwdata[7:0];
          REG_CMD_B:   cmd_codes[1] = cfg_pwdata[7:0];
          REG_CMD_C:   cmd_codes[2] = cfg_pwdata[7:0];
          REG_CMD_D:   cmd_codes[3] = cfg_pwdata[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        bytes_accepted++;
        if (parse_rx_byte(in_rx_byte, want)) expected_events.push_back(want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_events.size() == 0) begin
          mismatches++;
          $display("%0t: result with nothing expected, expected none, actual kind %h",
                   $time, out_event_kind);
        end else begin
          want = expected_events.pop_front();
          kind_seen[want.event_kind]++;
          check_field("event_kind", 16'(want.event_kind), 16'(out_event_kind));
          check_field("frame_type", 16'(want.frame_type), 16'(out_frame_type));
          check_field("frame_flags", 16'(want.frame_flags), 16'(out_frame_flags));
          check_field("scan_number", want.scan_number, out_scan_number);
          check_field("sequence_number", want.sequence_number, out_sequence_number);
          check_field("payload_length", 16'(want.payload_length), 16'(out_payload_length));
          check_field("payload_byte", 16'(want.payload_byte), 16'(out_payload_byte));
          check_field("payload_offset", 16'(want.payload_offset), 16'(out_payload_offset));
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, expected_events.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Receiver back-pressure: switch at random between stall patterns
  rx_mode_e rx_mode = RX_ALWAYS;
  int       mode_left = 0;
  int       run_left = 0;
  bit       run_level = 1'b0;

  always @(negedge clk) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(32, 256);
    end
    mode_left--;
    case (rx_mode)
      RX_ALWAYS: out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (run_left == 0) begin
          run_left  = $urandom_range(1, 12);
          run_level = !run_level;
        end
        run_left--;
        out_ready <= run_level;
      end
    endcase
  end

  // Send queued bytes in bursts with random gaps; leave valid low at the end
  task automatic flush_tx();
    int gap;
    bit drain;
    @(negedge clk);
    while (tx_bytes.size() != 0) begin
      if (burst_left == 0) begin
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 160)
                                                  : $urandom_range(1, 16);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        drain = ($urandom_range(0, 199) == 0);
        if (gap != 0 || drain) begin
          in_valid <= 1'b0;
          repeat ((gap == 0) ? 1 : gap) @(negedge clk);
          while (drain && expected_events.size() != 0) @(negedge clk);
        end
      end
      in_valid   <= 1'b1;
      in_rx_byte <= tx_bytes.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // Wait until every result has drained and the pipeline is quiet
  task automatic wait_idle();
    while (expected_events.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic cfg_read_check(input logic [2:0] idx);
    logic [31:0] data;
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    data = cfg_prdata;
    if (data !== {24'd0, reg_value(idx)}) begin
      mismatches++;
      $display("%0t: register %0d readback, expected %h, actual %h",
               $time, idx, {24'd0, reg_value(idx)}, data);
    end
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apply_config(input logic [7:0] ver, input logic [7:0] ca,
                              input logic [7:0] cb, input logic [7:0] cc,
                              input logic [7:0] cd);
    wait_idle();
    cfg_write(REG_VERSION, ver);
    cfg_write(REG_CMD_A, ca);
    cfg_write(REG_CMD_B, cb);
    cfg_write(REG_CMD_C, cc);
    cfg_write(REG_CMD_D, cd);
  endtask

  // Queue sync, header, payload and CRC of one frame; oversize lengths stop after the header
  task automatic add_frame(input logic [7:0] ver, input logic [7:0] typ,
                           input logic [7:0] flags, input logic [15:0] scan,
                           input logic [15:0] seq, input logic [7:0] len,
                           input bit bad_crc, input bit alt_fill);
    logic [7:0]  hb [8];
    logic [7:0]  pb;
    logic [15:0] c;
    int          i;
    hb = '{ver, typ, flags, scan[7:0], scan[15:8], seq[7:0], seq[15:8], len};
    c  = CRC_INIT;
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(SYNC_SECOND);
    for (i = 0; i < 8; i++) begin
      tx_bytes.push_back(hb[i]);
      c = crc_next(c, hb[i]);
    end
    frame_bytes_queued += 10;
    if (len <= LEN_LIMIT) begin
      for (i = 0; i < int'(len); i++) begin
        pb = alt_fill ? ((i % 2 != 0) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
        tx_bytes.push_back(pb);
        c = crc_next(c, pb);
      end
      if (bad_crc) c = c ^ (16'h0001 << $urandom_range(0, 15));
      tx_bytes.push_back(c[7:0]);
      tx_bytes.push_back(c[15:8]);
      frame_bytes_queued += int'(len) + 2;
    end
  endtask

  task automatic test_register_access();
    logic [2:0] idx;
    for (idx = REG_VERSION; idx <= REG_CMD_D; idx++) cfg_read_check(idx);
    cfg_write(REG_VERSION, 8'hFF);
    cfg_write(REG_CMD_A, 8'h00);
    cfg_write(REG_CMD_B, 8'hAA);
    cfg_write(REG_CMD_C, 8'h55);
    cfg_write(REG_CMD_D, 8'hFF);
    // Writes past the register list must leave everything alone
    cfg_write(REG_SPARE_FIRST, 8'h3C);
    cfg_write(REG_SPARE_LAST, 8'hC3);
    for (idx = REG_VERSION; idx <= REG_CMD_D; idx++) cfg_read_check(idx);
    apply_config(8'd1, 8'd1, 8'd2, 8'd3, 8'd4);
  endtask

  task automatic test_sync_and_accept();
    // Repeated first sync bytes keep the hunt armed
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(SYNC_FIRST);
    add_frame(8'd1, 8'd4, 8'hFF, 16'hFFFF, 16'h0000, 8'd0, 1'b0, 1'b0);
    add_frame(8'd1, 8'd1, 8'h00, 16'h0000, 16'hFFFF, 8'd2, 1'b0, 1'b1);
    flush_tx();
    wait_idle();
  endtask

  task automatic test_verdict_order();
    // Broken sync pair first, then crc beats version beats type
    tx_bytes.push_back(SYNC_FIRST);
    tx_bytes.push_back(8'h00);
    add_frame(8'hFF, 8'hEE, 8'h81, 16'h1234, 16'h8001, 8'd1, 1'b1, 1'b0);
    add_frame(8'hFF, 8'hEE, 8'h7E, 16'h8000, 16'h7FFF, 8'd0, 1'b0, 1'b0);
    add_frame(8'd1, 8'h00, 8'h5A, 16'hA5A5, 16'h5A5A, 8'd0, 1'b0, 1'b0);
    flush_tx();
    wait_idle();
  endtask

  task automatic test_length_limits();
    add_frame(8'd1, 8'd2, 8'h01, 16'h0001, 16'h0100, LEN_LIMIT + 8'd1, 1'b0, 1'b0);
    add_frame(8'd1, 8'd3, 8'h02, 16'h0002, 16'h0200, 8'hFF, 1'b0, 1'b0);
    add_frame(8'd1, 8'd3, 8'h04, 16'h0004, 16'h0400, LEN_LIMIT, 1'b0, 1'b0);
    add_frame(8'd1, 8'd2, 8'h08, 16'h0008, 16'h0800, LEN_LIMIT - 8'd1, 1'b0, 1'b0);
    flush_tx();
    wait_idle();
  endtask

  // Mostly well-formed frames with random content; some noise, false syncs and cut frames
  task automatic test_random_traffic(input int target);
    int         start;
    int         r;
    int         cut;
    bit         paused;
    logic [7:0] ver;
    logic [7:0] typ;
    logic [7:0] len;
    logic [7:0] junk;
    start  = frame_bytes_queued;
    paused = 1'b0;
    while (frame_bytes_queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        repeat ($urandom_range(1, 6)) tx_bytes.push_back(8'($urandom_range(0, 255)));
      end else if (r < 20) begin
        repeat ($urandom_range(1, 3)) tx_bytes.push_back(SYNC_FIRST);
      end else if (r < 25) begin
        junk = 8'($urandom_range(0, 255));
        tx_bytes.push_back(SYNC_FIRST);
        tx_bytes.push_back((junk == SYNC_SECOND) ? 8'h00 : junk);
      end
      ver = ($urandom_range(0, 99) < 85) ? cfg_version : 8'($urandom_range(0, 255));
      typ = ($urandom_range(0, 99) < 75) ? cmd_codes[$urandom_range(0, 3)]
                                         : 8'($urandom_range(0, 255));
      r = $urandom_range(0, 99);
      if (r < 70) len = 8'($urandom_range(0, 10));
      else if (r < 92) len = 8'($urandom_range(11, int'(LEN_LIMIT)));
      else if (r < 97) len = 8'($urandom_range(int'(LEN_LIMIT) + 1, 255));
      else len = LEN_LIMIT;
      add_frame(ver, typ, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
                16'($urandom_range(0, 65535)), len, ($urandom_range(0, 9) == 0), 1'b0);
      // Occasionally cut the frame short so the next one lands mid-parse
      if ($urandom_range(0, 19) == 0) begin
        cut = $urandom_range(1, 8);
        while (cut > 0 && tx_bytes.size() > 1) begin
          void'(tx_bytes.pop_back());
          cut--;
        end
      end
      if (tx_bytes.size() >= $urandom_range(1, 60)) flush_tx();
      // Hold the sender once until every pending result has come back
      if (!paused && frame_bytes_queued - start >= target / 2) begin
        flush_tx();
        while (expected_events.size() != 0) @(negedge clk);
        paused = 1'b1;
      end
    end
    flush_tx();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_register_access();
    test_sync_and_accept();
    test_verdict_order();
    test_length_limits();
    test_random_traffic(150);
    apply_config(8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    test_random_traffic(150);
    apply_config(8'hFF, 8'hFF, 8'hFE, 8'h80, 8'h7F);
    test_random_traffic(150);
    apply_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)));
    test_random_traffic(150);

    // Drain and let the pipeline settle
    while (expected_events.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Run covered %0d bytes over four register settings, %0d results checked",
             bytes_accepted, results_seen);
    $display("Results by kind: payload %0d, accept %0d, bad length %0d, crc %0d, version %0d, type %0d",
             kind_seen[EV_PAYLOAD], kind_seen[EV_ACCEPT], kind_seen[EV_BADLEN],
             kind_seen[EV_CRC], kind_seen[EV_VERSION], kind_seen[EV_TYPE]);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
